### design/bcrp_pkg.sv
// ----------------------------------------------------------------------------
// bcrp_pkg
// Shared types and constants of the bucket chain rule placer: register
// indices, sequencer states and the control/status bundle of the remainder unit.
// ----------------------------------------------------------------------------
package bcrp_pkg;

	// default sizing
	localparam int BUCKETS_DEF     = 32;
	localparam int CHAIN_DEPTH_DEF = 4;
	localparam int MAX_QUEUES_DEF  = 8;

	// item and configuration widths
	localparam int IP_W        = 32;
	localparam int COUNT_W     = 16;
	localparam int QCOUNT_W    = 4;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	// remainder unit: divisor wide enough for the largest bucket count and queue limit
	localparam int DIV_W  = 11;
	localparam int STEP_W = 6;

	localparam int BUCKET_STEPS = 32;
	localparam int QUEUE_STEPS  = 8;

	localparam logic [COUNT_W-1:0]  COUNT_MAX           = 16'hFFFF;
	localparam logic [COUNT_W-1:0]  RULES_PER_TABLE_RST = 16'hFFFF;
	localparam logic [QCOUNT_W-1:0] QUEUE_COUNT_RST     = 4'd1;

	// register indices
	localparam logic [CFG_INDEX_W-1:0] REG_RULES_PER_TABLE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_QUEUE_COUNT     = 8'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_BMOD,
		ST_RD_TBL,
		ST_RD_CUR,
		ST_RD_NXT,
		ST_QMOD,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic              start;
		logic [IP_W-1:0]   dividend;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0]  divisor;
	} rem_ctrl_t;

	typedef struct packed {
		logic             busy;
		logic [DIV_W-1:0] rem;
	} rem_stat_t;

endpackage

### design/bcrp_rem_unit.sv
// ----------------------------------------------------------------------------
// bcrp_rem_unit
// Iterative remainder unit: restoring division, one dividend bit per cycle,
// taken from the top of a left-aligned dividend.
// ----------------------------------------------------------------------------
module bcrp_rem_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bcrp_pkg::rem_ctrl_t   ctrl,
	output bcrp_pkg::rem_stat_t   stat
);

	logic                              busy_q;
	logic [bcrp_pkg::STEP_W-1:0]       cnt_q;
	logic [bcrp_pkg::IP_W-1:0]         dvd_q;
	logic [bcrp_pkg::DIV_W-1:0]        rem_q;
	logic [bcrp_pkg::DIV_W-1:0]        div_q;

	logic [bcrp_pkg::DIV_W:0]          trial;
	logic [bcrp_pkg::DIV_W:0]          diff;
	logic [bcrp_pkg::DIV_W-1:0]        rem_nxt;

	// one shift-compare-subtract step
	always_comb begin
		trial = {rem_q, dvd_q[bcrp_pkg::IP_W-1]};
		diff  = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_nxt = diff[bcrp_pkg::DIV_W-1:0];
		end else begin
			rem_nxt = trial[bcrp_pkg::DIV_W-1:0];
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= ctrl.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - bcrp_pkg::STEP_W'(1);
			if (cnt_q == bcrp_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// operands and partial remainder
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= ctrl.dividend;
			div_q <= ctrl.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[bcrp_pkg::IP_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.rem  = rem_q;

endmodule

### design/bucket_chain_rule_placer.sv
// ----------------------------------------------------------------------------
// bucket_chain_rule_placer
// Places one flow rule per destination address into a per-bucket chain of
// overflow tables and reports group, default-rule and receive-queue details.
// ----------------------------------------------------------------------------
// One item at a time. With a power-of-two BUCKETS an item passes from acceptance
// to result through a table read and two count memory reads, the queue remainder
// (one dividend bit a cycle through the shared remainder unit, over the top eight
// address bits) and the count update. Any other BUCKETS first puts the bucket
// remainder through the same unit over all 32 address bits. After reset a clearing
// pass over all BUCKETS*CHAIN_DEPTH count entries zeroes the stores, during
// which no item is taken; configuration writes are taken at all times. A new
// item is taken while the previous result still waits at the output.
module bucket_chain_rule_placer #(
	parameter int BUCKETS     = bcrp_pkg::BUCKETS_DEF,
	parameter int CHAIN_DEPTH = bcrp_pkg::CHAIN_DEPTH_DEF,
	parameter int MAX_QUEUES  = bcrp_pkg::MAX_QUEUES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bcrp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [bcrp_pkg::CFG_DATA_W-1:0]     cfg_data,
	// input items
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bcrp_pkg::IP_W-1:0]           dst_ip,
	// result items
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [4:0]                          bucket_index,
	output logic [6:0]                          root_jump_group,
	output logic [7:0]                          rule_group,
	output logic [1:0]                          table_slot,
	output logic                                install_default,
	output logic                                default_is_drop,
	output logic [7:0]                          default_next_group,
	output logic [2:0]                          queue_index,
	output logic                                chain_full
);

	localparam int N    = BUCKETS * CHAIN_DEPTH;
	localparam int AW   = $clog2(N);
	localparam int BW   = $clog2(BUCKETS);
	localparam int TW   = $clog2(CHAIN_DEPTH);
	localparam int GW   = ($clog2(N + 2) > 8) ? $clog2(N + 2) : 8;
	localparam int BXW  = (BW > 5) ? BW : 5;
	localparam int TXW  = (TW > 2) ? TW : 2;
	localparam bit BPOW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

	localparam int CW = bcrp_pkg::COUNT_W;
	localparam int DW = bcrp_pkg::DIV_W;

	// stores
	logic [CW-1:0] cnt_mem [N];
	logic [TW-1:0] tiu_mem [BUCKETS];

	// control state
	bcrp_pkg::state_t state_q, state_d;
	logic [AW-1:0]                     clr_q;
	logic [CW-1:0]                     rpt_q;
	logic [bcrp_pkg::QCOUNT_W-1:0]     qc_q;
	logic                              out_valid_q;

	// item payload
	logic [bcrp_pkg::IP_W-1:0]         ip_q;
	logic [BW-1:0]                     bucket_q;
	logic [TW-1:0]                     tbl_q;
	logic [CW-1:0]                     cnt_rd_q;
	logic [CW-1:0]                     cnt_cur_q;

	// result registers
	logic [4:0]                        bucket_index_q;
	logic [6:0]                        root_jump_group_q;
	logic [7:0]                        rule_group_q;
	logic [1:0]                        table_slot_q;
	logic                              install_default_q;
	logic                              default_is_drop_q;
	logic [7:0]                        default_next_group_q;
	logic [2:0]                        queue_index_q;
	logic                              chain_full_q;

	// remainder unit link
	bcrp_pkg::rem_ctrl_t               rem_ctrl;
	bcrp_pkg::rem_stat_t               rem_stat;

	// memory port controls
	logic                              cnt_we;
	logic [AW-1:0]                     cnt_waddr;
	logic [CW-1:0]                     cnt_wdata;
	logic                              cnt_re;
	logic [AW-1:0]                     cnt_raddr;
	logic                              tiu_we;
	logic [BW-1:0]                     tiu_waddr;
	logic [TW-1:0]                     tiu_wdata;
	logic                              tiu_re;
	logic                              ld_out;
	logic                              in_acc;

	// placement decision
	logic [AW-1:0]                     base;
	logic [AW-1:0]                     cur_addr;
	logic [AW-1:0]                     nxt_addr;
	logic [CW-1:0]                     limit;
	logic                              full_cur;
	logic                              last_cur;
	logic                              is_full;
	logic [TW-1:0]                     tbl_new;
	logic [CW-1:0]                     cnt_sel;
	logic                              inst;
	logic                              drop;
	logic [GW-1:0]                     group;
	logic [GW-1:0]                     next_grp;
	logic [GW-1:0]                     root;
	logic [DW-1:0]                     qn;
	logic [BXW-1:0]                    bucket_ext;
	logic [TXW-1:0]                    tbl_ext;

	bcrp_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (rem_ctrl),
		.stat   (rem_stat)
	);

	assign in_acc = in_valid && in_ready;

	// table addressing, limits and the decision itself
	always_comb begin
		base     = AW'(bucket_q) * AW'(CHAIN_DEPTH);
		cur_addr = base + AW'(tbl_q);
		last_cur = (tbl_q == TW'(CHAIN_DEPTH - 1));
		nxt_addr = last_cur ? cur_addr : cur_addr + AW'(1);
		limit    = (rpt_q == '0) ? CW'(1) : rpt_q;
		full_cur = (cnt_cur_q >= limit);
		is_full  = full_cur && last_cur;
		tbl_new  = full_cur ? tbl_q + TW'(1) : tbl_q;
		cnt_sel  = full_cur ? cnt_rd_q : cnt_cur_q;
		inst     = (cnt_sel == '0);
		drop     = inst && (tbl_new == TW'(CHAIN_DEPTH - 1));
		root     = GW'(base) + GW'(1);
		group    = GW'(base) + GW'(tbl_new) + GW'(1);
		next_grp = (inst && !drop) ? group + GW'(1) : '0;
		bucket_ext = BXW'(bucket_q);
		tbl_ext    = TXW'(tbl_new);
		// clamp the queue count into one to the queue limit
		if (qc_q == '0) begin
			qn = DW'(1);
		end else if (DW'(qc_q) > DW'(MAX_QUEUES)) begin
			qn = DW'(MAX_QUEUES);
		end else begin
			qn = DW'(qc_q);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bcrp_pkg::ST_CLEAR: begin
				if (clr_q == AW'(N - 1)) begin
					state_d = bcrp_pkg::ST_IDLE;
				end
			end
			bcrp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = BPOW2 ? bcrp_pkg::ST_RD_TBL : bcrp_pkg::ST_BMOD;
				end
			end
			bcrp_pkg::ST_BMOD: begin
				if (!rem_stat.busy) begin
					state_d = bcrp_pkg::ST_RD_TBL;
				end
			end
			bcrp_pkg::ST_RD_TBL: state_d = bcrp_pkg::ST_RD_CUR;
			bcrp_pkg::ST_RD_CUR: state_d = bcrp_pkg::ST_RD_NXT;
			bcrp_pkg::ST_RD_NXT: state_d = bcrp_pkg::ST_QMOD;
			bcrp_pkg::ST_QMOD: begin
				if (!rem_stat.busy) begin
					state_d = bcrp_pkg::ST_WRITE;
				end
			end
			bcrp_pkg::ST_WRITE: begin
				if (!out_valid_q || out_ready) begin
					state_d = bcrp_pkg::ST_IDLE;
				end
			end
			default: state_d = bcrp_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready           = 1'b0;
		rem_ctrl.start     = 1'b0;
		rem_ctrl.dividend  = dst_ip;
		rem_ctrl.steps     = bcrp_pkg::STEP_W'(bcrp_pkg::BUCKET_STEPS);
		rem_ctrl.divisor   = DW'(BUCKETS);
		cnt_we             = 1'b0;
		cnt_waddr          = full_cur ? nxt_addr : cur_addr;
		cnt_wdata          = (cnt_sel == bcrp_pkg::COUNT_MAX) ? cnt_sel : cnt_sel + CW'(1);
		cnt_re             = 1'b0;
		cnt_raddr          = cur_addr;
		tiu_we             = 1'b0;
		tiu_waddr          = bucket_q;
		tiu_wdata          = tbl_new;
		tiu_re             = 1'b0;
		ld_out             = 1'b0;
		case (state_q)
			bcrp_pkg::ST_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
				tiu_we    = ({1'b0, clr_q} < (AW + 1)'(BUCKETS));
				tiu_waddr = clr_q[BW-1:0];
				tiu_wdata = '0;
			end
			bcrp_pkg::ST_IDLE: begin
				in_ready       = 1'b1;
				rem_ctrl.start = in_valid && !BPOW2;
			end
			bcrp_pkg::ST_RD_TBL: begin
				tiu_re = 1'b1;
			end
			bcrp_pkg::ST_RD_CUR: begin
				cnt_re = 1'b1;
			end
			bcrp_pkg::ST_RD_NXT: begin
				cnt_re            = 1'b1;
				cnt_raddr         = nxt_addr;
				rem_ctrl.start    = 1'b1;
				rem_ctrl.dividend = {ip_q[31:24], 24'd0};
				rem_ctrl.steps    = bcrp_pkg::STEP_W'(bcrp_pkg::QUEUE_STEPS);
				rem_ctrl.divisor  = qn;
			end
			bcrp_pkg::ST_WRITE: begin
				ld_out = !out_valid_q || out_ready;
				cnt_we = ld_out && !is_full;
				tiu_we = ld_out && !is_full && full_cur;
			end
			default: begin
			end
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcrp_pkg::ST_CLEAR;
			clr_q       <= '0;
			rpt_q       <= bcrp_pkg::RULES_PER_TABLE_RST;
			qc_q        <= bcrp_pkg::QUEUE_COUNT_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bcrp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_valid) begin
				if (cfg_index == bcrp_pkg::REG_RULES_PER_TABLE) begin
					rpt_q <= cfg_data;
				end else if (cfg_index == bcrp_pkg::REG_QUEUE_COUNT) begin
					qc_q <= cfg_data[bcrp_pkg::QCOUNT_W-1:0];
				end
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stores, read data registered
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_raddr];
		end
		if (tiu_we) begin
			tiu_mem[tiu_waddr] <= tiu_wdata;
		end
		if (tiu_re) begin
			tbl_q <= tiu_mem[bucket_q];
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ip_q <= dst_ip;
			if (BPOW2) begin
				bucket_q <= dst_ip[BW-1:0];
			end
		end
		if (state_q == bcrp_pkg::ST_BMOD && !rem_stat.busy) begin
			bucket_q <= rem_stat.rem[BW-1:0];
		end
		if (state_q == bcrp_pkg::ST_RD_NXT) begin
			cnt_cur_q <= cnt_rd_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			bucket_index_q    <= bucket_ext[4:0];
			root_jump_group_q <= root[6:0];
			chain_full_q      <= is_full;
			if (is_full) begin
				rule_group_q         <= '0;
				table_slot_q         <= '0;
				install_default_q    <= 1'b0;
				default_is_drop_q    <= 1'b0;
				default_next_group_q <= '0;
				queue_index_q        <= '0;
			end else begin
				rule_group_q         <= group[7:0];
				table_slot_q         <= tbl_ext[1:0];
				install_default_q    <= inst;
				default_is_drop_q    <= drop;
				default_next_group_q <= next_grp[7:0];
				queue_index_q        <= rem_stat.rem[2:0];
			end
		end
	end

	assign cfg_ready          = 1'b1;
	assign out_valid          = out_valid_q;
	assign bucket_index       = bucket_index_q;
	assign root_jump_group    = root_jump_group_q;
	assign rule_group         = rule_group_q;
	assign table_slot         = table_slot_q;
	assign install_default    = install_default_q;
	assign default_is_drop    = default_is_drop_q;
	assign default_next_group = default_next_group_q;
	assign queue_index        = queue_index_q;
	assign chain_full         = chain_full_q;

endmodule
